/* hw/rtl/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, limits and pipeline payload types of the swept sphere
// contact core.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int COORD_WIDTH_DEF    = 21;
   localparam int TIME_FRAC_BITS_DEF = 16;

   localparam int WORD_W   = 63;
   localparam int RAD_W    = 20;
   localparam int SUM_R_W  = RAD_W + 1;
   localparam int DIFF_W   = 22;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int QUAD_W   = PROD_W + 2;
   localparam int SQ_BITS  = 22;
   localparam int SQ_IN_W  = 2 * SQ_BITS;
   localparam int TIME_W   = 17;
   localparam int NORM_W   = 24;
   localparam int DEPTH_W  = 23;

   localparam logic signed [NORM_W-1:0]  NORMAL_LIM = 24'sd4194304;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN  = {1'b1, {(DEPTH_W-1){1'b0}}};
   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX  = 23'sd2097150;

   typedef logic signed [DIFF_W-1:0] diff_type;

   typedef struct packed {
      logic a_zero;
      logic k_nonpos;
      logic k_neg;
      logic no_hit;
   } flag_type;

   typedef struct packed {
      diff_type [2:0]     c;
      diff_type [2:0]     v;
      logic [SUM_R_W-1:0] r;
      flag_type           flags;
   } item_type;

   typedef struct packed {
      logic signed [QUAD_W-1:0] a;
      logic signed [QUAD_W-1:0] h;
   } coef_type;

   typedef struct packed {
      logic [SQ_IN_W-1:0]   x;
      logic [SQ_BITS+1:0]   rem;
      logic [SQ_BITS-1:0]   root;
   } sqrt_type;

endpackage

/* hw/rtl/ssc_front.sv */
// ----------------------------------------------------------------------------
// ssc_front
// Six stages: relative offset and motion, products, quadratic terms,
// classification with split products, discriminant sums and compare.
// ----------------------------------------------------------------------------
module ssc_front #(
   parameter int COORD_WIDTH = ssc_pkg::COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [ssc_pkg::WORD_W-1:0]         pos_a,
   input  logic [ssc_pkg::WORD_W-1:0]         vel_a,
   input  logic [ssc_pkg::RAD_W-1:0]          radius_a,
   input  logic [ssc_pkg::WORD_W-1:0]         pos_b,
   input  logic [ssc_pkg::WORD_W-1:0]         vel_b,
   input  logic [ssc_pkg::RAD_W-1:0]          radius_b,
   output logic                               out_valid,
   output ssc_pkg::item_type                  item,
   output ssc_pkg::coef_type                  coef,
   output logic signed [ssc_pkg::QUAD_W-1:0]  k,
   output logic [ssc_pkg::SQ_IN_W-1:0]        c2
);
   import ssc_pkg::*;

   localparam int HALF_W = PROD_W / 2;
   localparam int EW     = QUAD_W + 2;
   localparam int DW     = 2 * PROD_W;

   logic [5:0] valid_ff;

   item_type item_in;
   item_type item1_ff, item2_ff, item3_ff, item4_ff, item5_ff, item6_ff;

   logic signed [PROD_W-1:0]    pvv_ff [3];
   logic signed [PROD_W-1:0]    pvc_ff [3];
   logic signed [PROD_W-1:0]    pcc_ff [3];
   logic [2*SUM_R_W-1:0]        r2_ff;

   logic signed [QUAD_W-1:0] a3_ff, h3_ff, c23_ff, k3_ff;
   logic signed [QUAD_W-1:0] a4_ff, h4_ff, c24_ff, k4_ff;
   logic signed [QUAD_W-1:0] a5_ff, h5_ff, c25_ff, k5_ff;
   logic signed [QUAD_W-1:0] a6_ff, h6_ff, c26_ff, k6_ff;

   logic a_zero4_ff, k_nonpos4_ff, k_neg4_ff, h_nonneg4_ff, after4_ff;
   logic a_zero5_ff, k_nonpos5_ff, k_neg5_ff, h_nonneg5_ff, after5_ff;
   logic [PROD_W-1:0] hh11_ff, hh10_ff, hh00_ff, ak11_ff, ak10_ff, ak01_ff, ak00_ff;
   logic [DW-1:0]     hh5_ff, ak5_ff;

   logic [PROD_W-1:0]   hm, km, am;
   logic signed [EW-1:0] tail;

   always_comb begin
      item_in = '0;
      for (int i = 0; i < 3; i++) begin
         item_in.c[i] = diff_type'($signed(pos_a[i*COORD_WIDTH +: COORD_WIDTH]))
                      - diff_type'($signed(pos_b[i*COORD_WIDTH +: COORD_WIDTH]));
         item_in.v[i] = diff_type'($signed(vel_a[i*COORD_WIDTH +: COORD_WIDTH]))
                      - diff_type'($signed(vel_b[i*COORD_WIDTH +: COORD_WIDTH]));
      end
      item_in.r = SUM_R_W'(radius_a) + SUM_R_W'(radius_b);
   end

   always_comb begin
      hm   = h3_ff[QUAD_W-1] ? PROD_W'(-h3_ff) : PROD_W'(h3_ff);
      km   = (k3_ff[QUAD_W-1] || (k3_ff == '0)) ? '0 : PROD_W'(k3_ff);
      am   = PROD_W'(a3_ff);
      tail = EW'(a3_ff) + (EW'(h3_ff) <<< 1) + EW'(k3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item1_ff <= item_in;

         item2_ff <= item1_ff;
         for (int i = 0; i < 3; i++) begin
            pvv_ff[i] <= $signed(item1_ff.v[i]) * $signed(item1_ff.v[i]);
            pvc_ff[i] <= $signed(item1_ff.v[i]) * $signed(item1_ff.c[i]);
            pcc_ff[i] <= $signed(item1_ff.c[i]) * $signed(item1_ff.c[i]);
         end
         r2_ff <= item1_ff.r * item1_ff.r;

         item3_ff <= item2_ff;
         a3_ff  <= QUAD_W'(pvv_ff[0]) + QUAD_W'(pvv_ff[1]) + QUAD_W'(pvv_ff[2]);
         h3_ff  <= QUAD_W'(pvc_ff[0]) + QUAD_W'(pvc_ff[1]) + QUAD_W'(pvc_ff[2]);
         c23_ff <= QUAD_W'(pcc_ff[0]) + QUAD_W'(pcc_ff[1]) + QUAD_W'(pcc_ff[2]);
         k3_ff  <= QUAD_W'(pcc_ff[0]) + QUAD_W'(pcc_ff[1]) + QUAD_W'(pcc_ff[2])
                 - $signed(QUAD_W'(r2_ff));

         item4_ff     <= item3_ff;
         a4_ff        <= a3_ff;
         h4_ff        <= h3_ff;
         c24_ff       <= c23_ff;
         k4_ff        <= k3_ff;
         a_zero4_ff   <= (a3_ff == '0);
         k_nonpos4_ff <= k3_ff[QUAD_W-1] || (k3_ff == '0);
         k_neg4_ff    <= k3_ff[QUAD_W-1];
         h_nonneg4_ff <= !h3_ff[QUAD_W-1];
         after4_ff    <= ((-h3_ff) > a3_ff) && !tail[EW-1] && (tail != '0);
         hh11_ff <= hm[PROD_W-1:HALF_W] * hm[PROD_W-1:HALF_W];
         hh10_ff <= hm[PROD_W-1:HALF_W] * hm[HALF_W-1:0];
         hh00_ff <= hm[HALF_W-1:0] * hm[HALF_W-1:0];
         ak11_ff <= am[PROD_W-1:HALF_W] * km[PROD_W-1:HALF_W];
         ak10_ff <= am[PROD_W-1:HALF_W] * km[HALF_W-1:0];
         ak01_ff <= am[HALF_W-1:0] * km[PROD_W-1:HALF_W];
         ak00_ff <= am[HALF_W-1:0] * km[HALF_W-1:0];

         item5_ff     <= item4_ff;
         a5_ff        <= a4_ff;
         h5_ff        <= h4_ff;
         c25_ff       <= c24_ff;
         k5_ff        <= k4_ff;
         a_zero5_ff   <= a_zero4_ff;
         k_nonpos5_ff <= k_nonpos4_ff;
         k_neg5_ff    <= k_neg4_ff;
         h_nonneg5_ff <= h_nonneg4_ff;
         after5_ff    <= after4_ff;
         hh5_ff <= (DW'(hh11_ff) << PROD_W) + (DW'(hh10_ff) << (HALF_W + 1))
                 + DW'(hh00_ff);
         ak5_ff <= (DW'(ak11_ff) << PROD_W)
                 + ((DW'(ak10_ff) + DW'(ak01_ff)) << HALF_W) + DW'(ak00_ff);

         item6_ff <= '{c: item5_ff.c, v: item5_ff.v, r: item5_ff.r,
                       flags: '{a_zero: a_zero5_ff, k_nonpos: k_nonpos5_ff,
                                k_neg: k_neg5_ff,
                                no_hit: h_nonneg5_ff || after5_ff || (hh5_ff < ak5_ff)}};
         a6_ff  <= a5_ff;
         h6_ff  <= h5_ff;
         c26_ff <= c25_ff;
         k6_ff  <= k5_ff;
      end
   end

   assign out_valid = valid_ff[5];
   assign item      = item6_ff;
   assign coef.a    = a6_ff;
   assign coef.h    = h6_ff;
   assign k         = k6_ff;
   assign c2        = SQ_IN_W'(c26_ff);

endmodule

/* hw/rtl/ssc_step.sv */
// ----------------------------------------------------------------------------
// ssc_step
// One pipeline stage: one bit of the impact time search and one bit of the
// offset length square root.
// ----------------------------------------------------------------------------
module ssc_step #(
   parameter int STEP           = 0,
   parameter int TIME_FRAC_BITS = ssc_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  ssc_pkg::item_type                        in_item,
   input  ssc_pkg::coef_type                        in_coef,
   input  ssc_pkg::sqrt_type                        in_sq,
   input  logic signed [2*TIME_FRAC_BITS+47:0]      in_g,
   input  logic signed [2*TIME_FRAC_BITS+47:0]      in_aq,
   input  logic [TIME_FRAC_BITS:0]                  in_q,
   output logic                                     out_valid,
   output ssc_pkg::item_type                        out_item,
   output ssc_pkg::coef_type                        out_coef,
   output ssc_pkg::sqrt_type                        out_sq,
   output logic signed [2*TIME_FRAC_BITS+47:0]      out_g,
   output logic signed [2*TIME_FRAC_BITS+47:0]      out_aq,
   output logic [TIME_FRAC_BITS:0]                  out_q
);
   import ssc_pkg::*;

   localparam int GW   = 2 * TIME_FRAC_BITS + 48;
   localparam int QW   = TIME_FRAC_BITS + 1;
   localparam bit SRCH = (STEP <= TIME_FRAC_BITS);
   localparam int J    = SRCH ? TIME_FRAC_BITS - STEP : 0;
   localparam bit SQ   = (STEP < SQ_BITS);
   localparam int SI   = SQ ? SQ_BITS - 1 - STEP : 0;

   logic                  valid_ff;
   item_type              item_ff;
   coef_type              coef_ff;
   sqrt_type              sq_ff;
   logic signed [GW-1:0]  g_ff, aq_ff;
   logic [QW-1:0]         q_ff;

   logic signed [GW-1:0]  a_ext, h_ext, cand_g, cand_aq, side;
   logic                  take;
   logic [SQ_BITS+3:0]    rem_x, trial;
   logic                  ge;
   sqrt_type              sq_in;
   logic signed [GW-1:0]  g_in, aq_in;
   logic [QW-1:0]         q_in;

   always_comb begin
      a_ext   = GW'(in_coef.a);
      h_ext   = GW'(in_coef.h);
      cand_g  = in_g + (in_aq <<< (J + 1)) + (a_ext <<< (2 * J))
              + (h_ext <<< (J + 1 + TIME_FRAC_BITS));
      cand_aq = in_aq + (a_ext <<< J);
      side    = cand_aq + (h_ext <<< TIME_FRAC_BITS);
      take    = SRCH && !((J < TIME_FRAC_BITS) && in_q[QW-1])
              && !cand_g[GW-1] && (side[GW-1] || (side == '0));
      g_in    = take ? cand_g : in_g;
      aq_in   = take ? cand_aq : in_aq;
      q_in    = take ? (in_q | (QW'(1) << J)) : in_q;

      rem_x = {in_sq.rem, in_sq.x[2*SI+1 -: 2]};
      trial = {2'b00, in_sq.root, 2'b01};
      ge    = (rem_x >= trial);
      sq_in = in_sq;
      if (SQ) begin
         sq_in.rem  = ge ? (SQ_BITS+2)'(rem_x - trial) : (SQ_BITS+2)'(rem_x);
         sq_in.root = {in_sq.root[SQ_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= in_item;
         coef_ff <= in_coef;
         sq_ff   <= sq_in;
         g_ff    <= g_in;
         aq_ff   <= aq_in;
         q_ff    <= q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_coef  = coef_ff;
   assign out_sq    = sq_ff;
   assign out_g     = g_ff;
   assign out_aq    = aq_ff;
   assign out_q     = q_ff;

endmodule

/* hw/rtl/ssc_back.sv */
// ----------------------------------------------------------------------------
// ssc_back
// Normal at the impact time, depth, case selection and the output register.
// ----------------------------------------------------------------------------
module ssc_back #(
   parameter int TIME_FRAC_BITS = ssc_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  ssc_pkg::item_type                   in_item,
   input  logic [ssc_pkg::SQ_BITS-1:0]         in_root,
   input  logic [TIME_FRAC_BITS:0]             in_q,
   output logic                                out_valid,
   output logic                                hit,
   output logic                                began_overlapped,
   output logic [ssc_pkg::TIME_W-1:0]          impact_time,
   output logic signed [ssc_pkg::NORM_W-1:0]   normal_x,
   output logic signed [ssc_pkg::NORM_W-1:0]   normal_y,
   output logic signed [ssc_pkg::NORM_W-1:0]   normal_z,
   output logic signed [ssc_pkg::DEPTH_W-1:0]  depth
);
   import ssc_pkg::*;

   localparam int QW  = TIME_FRAC_BITS + 1;
   localparam int PRW = DIFF_W + QW + 1;
   localparam int DDW = SQ_BITS + 3;

   logic                      valid1_ff, valid2_ff;
   item_type                  item1_ff;
   logic [SQ_BITS-1:0]        root1_ff;
   logic [QW-1:0]             q1_ff, qe;
   logic signed [PRW-1:0]     prod_ff [3];

   logic signed [PRW:0]       n_sum [3];
   logic signed [NORM_W-1:0]  n_sat [3];
   logic signed [DDW-1:0]     d_raw;
   logic signed [DEPTH_W-1:0] d_sat;

   logic                      hit_in, bo_in;
   logic [TIME_W-1:0]         time_in;
   logic signed [NORM_W-1:0]  nrm_in [3];
   logic signed [DEPTH_W-1:0] depth_in;

   logic                      hit_ff, bo_ff;
   logic [TIME_W-1:0]         time_ff;
   logic signed [NORM_W-1:0]  nrm_ff [3];
   logic signed [DEPTH_W-1:0] depth_ff;

   assign qe = in_item.flags.k_nonpos ? '0 : in_q;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_sum[i] = (PRW+1)'($signed(item1_ff.c[i])) + (PRW+1)'(prod_ff[i] >>> TIME_FRAC_BITS);
         if (n_sum[i] > (PRW+1)'(NORMAL_LIM)) begin
            n_sat[i] = NORMAL_LIM;
         end else if (n_sum[i] < -(PRW+1)'(NORMAL_LIM)) begin
            n_sat[i] = -NORMAL_LIM;
         end else begin
            n_sat[i] = NORM_W'(n_sum[i]);
         end
      end
      d_raw = $signed(DDW'(item1_ff.r)) - $signed(DDW'(root1_ff));
      if (d_raw > DDW'(DEPTH_MAX)) begin
         d_sat = DEPTH_MAX;
      end else if (d_raw < DDW'(DEPTH_MIN)) begin
         d_sat = DEPTH_MIN;
      end else begin
         d_sat = DEPTH_W'(d_raw);
      end
   end

   always_comb begin
      hit_in   = 1'b0;
      bo_in    = 1'b0;
      time_in  = '0;
      depth_in = '0;
      for (int i = 0; i < 3; i++) begin
         nrm_in[i] = '0;
      end
      if (item1_ff.flags.a_zero) begin
         hit_in = 1'b0;
      end else if (item1_ff.flags.k_nonpos) begin
         hit_in = 1'b1;
         bo_in  = item1_ff.flags.k_neg;
         for (int i = 0; i < 3; i++) begin
            nrm_in[i] = n_sat[i];
         end
         depth_in = item1_ff.flags.k_neg ? d_sat : '0;
      end else if (!item1_ff.flags.no_hit) begin
         hit_in  = 1'b1;
         time_in = TIME_W'(q1_ff);
         for (int i = 0; i < 3; i++) begin
            nrm_in[i] = n_sat[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item1_ff <= in_item;
         root1_ff <= in_root;
         q1_ff    <= qe;
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= $signed(in_item.v[i]) * $signed({1'b0, qe});
         end

         hit_ff   <= hit_in;
         bo_ff    <= bo_in;
         time_ff  <= time_in;
         depth_ff <= depth_in;
         for (int i = 0; i < 3; i++) begin
            nrm_ff[i] <= nrm_in[i];
         end
      end
   end

   assign out_valid        = valid2_ff;
   assign hit              = hit_ff;
   assign began_overlapped = bo_ff;
   assign impact_time      = time_ff;
   assign normal_x         = nrm_ff[0];
   assign normal_y         = nrm_ff[1];
   assign normal_z         = nrm_ff[2];
   assign depth            = depth_ff;

endmodule

/* hw/rtl/swept_sphere_contact_core.sv */
// ----------------------------------------------------------------------------
// swept_sphere_contact_core
// Swept sphere pair contact test: earliest touch within one step, or start
// overlap with penetration depth.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     sphere pair word
//   rsp      out  rsp_tvalid/tready     contact word, flags in tuser
//
// One word per cycle while the output is not stalled; the step stages carry the
// one-bit-per-stage time search and square root.
// Reset clears the stage valid bits only.
// A stall at the output freezes every stage; req_tready follows it.
// ----------------------------------------------------------------------------
module swept_sphere_contact_core #(
   parameter int COORD_WIDTH    = ssc_pkg::COORD_WIDTH_DEF,
   parameter int TIME_FRAC_BITS = ssc_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // pos_a[62:0] vel_a[125:63] radius_a[145:126] pos_b[208:146]
   // vel_b[271:209] radius_b[291:272] zero[295:292]
   input  logic [295:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // impact_time[16:0] normal_x[40:17] normal_y[64:41] normal_z[88:65]
   // depth[111:89]
   output logic [111:0]  rsp_tdata,
   // hit[0] began_overlapped[1]
   output logic [1:0]    rsp_tuser
);
   import ssc_pkg::*;

   localparam int GW = 2 * TIME_FRAC_BITS + 48;
   localparam int QW = TIME_FRAC_BITS + 1;
   localparam int NS = (QW > SQ_BITS) ? QW : SQ_BITS;

   logic en;

   logic                  st_valid [NS+1];
   item_type              st_item  [NS+1];
   coef_type              st_coef  [NS+1];
   sqrt_type              st_sq    [NS+1];
   logic signed [GW-1:0]  st_g     [NS+1];
   logic signed [GW-1:0]  st_aq    [NS+1];
   logic [QW-1:0]         st_q     [NS+1];

   logic signed [QUAD_W-1:0] k0;
   logic [SQ_IN_W-1:0]       c20;

   logic                      hit, bo;
   logic [TIME_W-1:0]         impact_time;
   logic signed [NORM_W-1:0]  nx, ny, nz;
   logic signed [DEPTH_W-1:0] depth;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   ssc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .pos_a     (req_tdata[62:0]),
      .vel_a     (req_tdata[125:63]),
      .radius_a  (req_tdata[145:126]),
      .pos_b     (req_tdata[208:146]),
      .vel_b     (req_tdata[271:209]),
      .radius_b  (req_tdata[291:272]),
      .out_valid (st_valid[0]),
      .item      (st_item[0]),
      .coef      (st_coef[0]),
      .k         (k0),
      .c2        (c20)
   );

   assign st_sq[0].x    = c20;
   assign st_sq[0].rem  = '0;
   assign st_sq[0].root = '0;
   assign st_g[0]       = GW'(k0) <<< (2 * TIME_FRAC_BITS);
   assign st_aq[0]      = '0;
   assign st_q[0]       = '0;

   for (genvar s = 0; s < NS; s++) begin : g_step
      ssc_step #(.STEP(s), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (st_valid[s]),
         .in_item   (st_item[s]),
         .in_coef   (st_coef[s]),
         .in_sq     (st_sq[s]),
         .in_g      (st_g[s]),
         .in_aq     (st_aq[s]),
         .in_q      (st_q[s]),
         .out_valid (st_valid[s+1]),
         .out_item  (st_item[s+1]),
         .out_coef  (st_coef[s+1]),
         .out_sq    (st_sq[s+1]),
         .out_g     (st_g[s+1]),
         .out_aq    (st_aq[s+1]),
         .out_q     (st_q[s+1])
      );
   end

   ssc_back #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (st_valid[NS]),
      .in_item          (st_item[NS]),
      .in_root          (st_sq[NS].root),
      .in_q             (st_q[NS]),
      .out_valid        (rsp_tvalid),
      .hit              (hit),
      .began_overlapped (bo),
      .impact_time      (impact_time),
      .normal_x         (nx),
      .normal_y         (ny),
      .normal_z         (nz),
      .depth            (depth)
   );

   assign rsp_tdata = {depth, nz, ny, nx, impact_time};
   assign rsp_tuser = {bo, hit};

endmodule

/* test/swept_sphere_contact_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_sphere_contact_core_test
// Streams sphere pairs into the contact core, predicts each contact word with
// an exact integer sweep solver and compares every returned word field by
// field, with random idle gaps on both sides except in every third random phase.
// ----------------------------------------------------------------------------
typedef struct {
   logic                hit;
   logic                overlapped;
   logic [16:0]         impact_time;
   logic signed [23:0]  normal [3];
   logic signed [22:0]  depth;
} contact_type;

class contact_ledger;
   contact_type pending_q[$];
   int          mismatches;
   int          hits;
   int          overlaps;
   int          checked;

   function longint coord(logic [62:0] w, int i);
      logic signed [20:0] x;
      x = w[i*21 +: 21];
      return longint'(x);
   endfunction

   function longint clamp(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function longint floor_root(longint x);
      longint res, t;
      res = 0;
      for (int b = 23; b >= 0; b--) begin
         t = res | (longint'(1) << b);
         if (t * t <= x) res = t;
      end
      return res;
   endfunction

   function bit before_root(longint a, longint h, longint k, longint q);
      logic signed [127:0] wa, wh, wk, wq, one, f;
      wa = a; wh = h; wk = k; wq = q; one = 65536;
      f = wa * wq * wq + 2 * wh * wq * one + wk * one * one;
      if (f < 0) return 0;
      f = -wh * one - wa * wq;
      return f >= 0;
   endfunction

   function void note(logic [295:0] d);
      longint c[3], v[3], a, h, c2, r, k, lo, hi, mid;
      logic signed [127:0] wa, wh, wk;
      contact_type e;
      e.hit = 0; e.overlapped = 0; e.impact_time = 0; e.depth = 0;
      a = 0; h = 0; c2 = 0;
      for (int i = 0; i < 3; i++) begin
         e.normal[i] = 0;
         c[i] = coord(d[62:0], i) - coord(d[208:146], i);
         v[i] = coord(d[125:63], i) - coord(d[271:209], i);
         a += v[i] * v[i];
         h += v[i] * c[i];
         c2 += c[i] * c[i];
      end
      r = longint'(d[145:126]) + longint'(d[291:272]);
      k = c2 - r * r;
      wa = a; wh = h; wk = k;
      if (a != 0) begin
         if (k <= 0) begin
            e.hit = 1;
            e.overlapped = k < 0;
            for (int i = 0; i < 3; i++)
               e.normal[i] = 24'(clamp(c[i], -4194304, 4194304));
            if (k < 0) e.depth = 23'(clamp(r - floor_root(c2), -4194304, 2097150));
         end else if (h < 0 && wh * wh - wa * wk >= 0 && !(-h > a && a + 2 * h + k > 0))
         begin
            lo = 0; hi = 65536;
            while (lo < hi) begin
               mid = lo + (hi - lo + 1) / 2;
               if (before_root(a, h, k, mid)) lo = mid;
               else hi = mid - 1;
            end
            e.hit = 1;
            e.impact_time = 17'(lo);
            for (int i = 0; i < 3; i++)
               e.normal[i] = 24'(clamp(c[i] + ((v[i] * lo) >>> 16), -4194304, 4194304));
         end
      end
      pending_q.push_back(e);
   endfunction

   function void check(logic [111:0] d, logic [1:0] u);
      contact_type e;
      bit bad;
      checked++;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected contact word %h flags %b", d, u);
         return;
      end
      e = pending_q.pop_front();
      hits += e.hit;
      overlaps += e.overlapped;
      bad = u[0] !== e.hit || u[1] !== e.overlapped || d[16:0] !== e.impact_time
         || d[40:17] !== e.normal[0] || d[64:41] !== e.normal[1]
         || d[88:65] !== e.normal[2] || d[111:89] !== e.depth;
      if (bad) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp hit %b ovl %b t %0d n %0d %0d %0d d %0d / got hit %b ovl %b t %0d n %0d %0d %0d d %0d",
               e.hit, e.overlapped, e.impact_time, e.normal[0], e.normal[1], e.normal[2],
               e.depth, u[0], u[1], d[16:0], $signed(d[40:17]), $signed(d[64:41]),
               $signed(d[88:65]), $signed(d[111:89]));
      end
   endfunction
endclass

module swept_sphere_contact_core_test;
   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [295:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [111:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;

   contact_ledger ledger = new();
   bit            gaps_on = 1;
   int            sent = 0;
   int            quiet = 0;

   swept_sphere_contact_core i_dut (.*);

   always #5 clock = ~clock;

   function int pick_gap();
      int p;
      p = $urandom_range(99);
      if (!gaps_on || p < 60) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function logic [62:0] vec(longint x, longint y, longint z);
      logic [62:0] w;
      w[20:0] = 21'(x); w[41:21] = 21'(y); w[62:42] = 21'(z);
      return w;
   endfunction

   function longint near(int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   task automatic send_pair(logic [62:0] pa, logic [62:0] va, logic [19:0] ra,
                            logic [62:0] pb, logic [62:0] vb, logic [19:0] rb);
      int g;
      req_tdata <= {4'b0, rb, vb, pb, ra, va, pa};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sent++;
      g = pick_gap();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_random();
      int mode, span, rspan;
      longint bx, by, bz;
      logic [62:0] pb;
      mode = $urandom_range(9);
      if (mode < 2) begin
         send_pair(63'({$urandom, $urandom}), 63'({$urandom, $urandom}), 20'($urandom),
                   63'({$urandom, $urandom}), 63'({$urandom, $urandom}), 20'($urandom));
      end else begin
         span = 1 << $urandom_range(16, 4);
         rspan = (mode == 9) ? 1048575 : $urandom_range(span);
         bx = near(500000); by = near(500000); bz = near(500000);
         pb = vec(bx, by, bz);
         send_pair(vec(bx + near(span), by + near(span), bz + near(span)),
                   vec(near(span), near(span), near(span)), 20'($urandom_range(rspan)),
                   pb, (mode == 8) ? 63'b0 : vec(near(span), near(span), near(span)),
                   20'($urandom_range(rspan)));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) ledger.note(req_tdata);
         if (rsp_tvalid && rsp_tready) ledger.check(rsp_tdata, rsp_tuser);
         quiet <= (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ? 0 : quiet + 1;
         if ($urandom_range(99) < 70 || !gaps_on) rsp_tready <= 1;
         else rsp_tready <= $urandom_range(99) < 10 ? 0 : $urandom_range(1);
      end
   end

   always @(posedge clock) begin
      if (quiet >= 20000) begin
         $display("watchdog: no progress");
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [62:0] pmax, pmin;
      pmax = vec(1048575, 1048575, 1048575);
      pmin = vec(-1048576, -1048576, -1048576);
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // no relative motion, zero and extreme words
      send_pair('0, '0, '0, '0, '0, '0);
      send_pair({63{1'b1}}, {63{1'b1}}, 20'hFFFFF, {63{1'b1}}, {63{1'b1}}, 20'hFFFFF);
      send_pair(pmax, pmax, 20'hFFFFF, pmin, pmin, 20'hFFFFF);
      send_pair(pmin, pmin, 0, pmax, pmax, 0);
      send_pair(pmax, pmin, 0, pmin, pmax, 0);
      send_pair(vec(100, 0, 0), vec(5, 5, 5), 300, 0, vec(5, 5, 5), 300);
      // overlap, exact touch, impact, separating, grazing miss, late root
      send_pair(vec(100, 0, 0), vec(1, 0, 0), 256, 0, 0, 256);
      send_pair(vec(512, 0, 0), vec(-3, 0, 0), 256, 0, 0, 256);
      send_pair(vec(512, 0, 0), vec(3, 0, 0), 256, 0, 0, 256);
      send_pair(vec(2000, 0, 0), vec(-2000, 0, 0), 256, 0, 0, 256);
      send_pair(vec(2000, 0, 0), vec(2000, 0, 0), 256, 0, 0, 256);
      send_pair(vec(2000, 0, 0), vec(0, 2000, 0), 256, 0, 0, 256);
      send_pair(vec(20000, 0, 0), vec(-1000, 0, 0), 256, 0, 0, 256);
      send_pair(vec(1512, 0, 0), vec(-1000, 0, 0), 256, 0, 0, 256);
      send_pair(vec(0, 0, -3000), 0, 1000, 0, vec(0, 0, -2000), 1000);
      send_pair(vec(1000, 1000, 0), vec(-1000, -900, 0), 600, 0, 0, 600);
      send_pair(vec(40, 0, 0), vec(0, 1, 0), 20'hFFFFF, 0, 0, 20'hFFFFF);
      req_tvalid <= 0;
      while (ledger.pending_q.size() != 0) @(posedge clock);
      for (int phase = 0; phase < 6; phase++) begin
         gaps_on = phase % 3 != 2;
         repeat (300) send_random();
      end
      req_tvalid <= 0;
      while (ledger.pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("%0d sphere pairs sent, %0d contact words checked", sent, ledger.checked);
      $display("%0d hits, %0d of them starting overlapped", ledger.hits, ledger.overlaps);
      if (ledger.mismatches == 0 && ledger.pending_q.size() == 0 && ledger.checked == sent)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
